/* rtl/epmd_pkg.sv */
// ----------------------------------------------------------------------------
// epmd_pkg
// Shared types and constants for the encoder PID motor drive.
// ----------------------------------------------------------------------------
package epmd_pkg;

    localparam logic [1:0] CMD_EDGE_A = 2'd0;
    localparam logic [1:0] CMD_EDGE_B = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_PERIOD     = 2'd1;
    localparam logic [1:0] REG_MIN_DUTY   = 2'd2;
    localparam logic [1:0] REG_REVERSE    = 2'd3;

    localparam logic [31:0] SPEED_NUMER = 32'd60000000;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_EDGE_A_START,   // latch inputs, start speed divide
        OP_EDGE_A_DONE,    // write speed, count
        OP_EDGE_B,
        OP_TICK_START,     // latch, stall check, error, start D divide
        OP_TICK_PI,        // P product and integral
        OP_TICK_DONE,      // sum, clamp, write demand
        OP_TICK_SKIP
    } op_t;

    typedef struct packed {
        op_t  op;
    } epmd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic run_pid;     // tick period elapsed
    } epmd_stat_t;

endpackage

/* rtl/epmd_div.sv */
// ----------------------------------------------------------------------------
// epmd_div
// Shared radix-2 restoring divider, signed magnitude, 32-bit quotient.
// One quotient bit per cycle; quotient truncates toward zero.
// ----------------------------------------------------------------------------
module epmd_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               neg,
    input  logic [31:0]        dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [32:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // one shift-subtract step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

/* rtl/epmd_datapath.sv */
// ----------------------------------------------------------------------------
// epmd_datapath
// Encoder state, PID arithmetic and duty mapping, driven by controller ops.
// ----------------------------------------------------------------------------
module epmd_datapath #(
    parameter int DUTY_BITS        = 8,
    parameter int STALL_TIMEOUT_US = 500000
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  epmd_pkg::epmd_cmd_t     ctl,
    output epmd_pkg::epmd_stat_t    stat,
    input  logic [1:0]              cmd,
    input  logic                    line_a,
    input  logic                    line_b,
    input  logic [31:0]             now_us,
    input  logic signed [25:0]      target_speed,
    input  logic [15:0]             prop_gain,
    input  logic [9:0]              loop_period_ms,
    input  logic [7:0]              min_duty,
    input  logic                    reverse_wiring,
    output logic [7:0]              duty_first,
    output logic [7:0]              duty_second,
    output logic [25:0]             measured_speed,
    output logic signed [31:0]      position
);
    import epmd_pkg::*;

    localparam int DB = DUTY_BITS + 1;
    localparam logic signed [47:0] DUTY_MAX = 48'sd1 <<< DUTY_BITS;

    logic                level_a_reg, level_b_reg;
    logic [31:0]         last_edge_reg, last_loop_reg;
    logic [25:0]         speed_reg;
    logic [31:0]         count_reg;
    logic signed [47:0]  integ_reg;
    logic signed [26:0]  prev_err_reg;
    logic signed [DB-1:0] demand_reg;
    logic [31:0]         now_reg;
    logic signed [26:0]  err_reg;
    logic signed [43:0]  p_reg;
    logic                pid_go_reg;

    logic [9:0]          period;
    logic [31:0]         interval;
    logic                div_start, div_neg, div_done;
    logic [31:0]         div_a, div_b;
    logic signed [32:0]  div_q;
    logic [25:0]         speed_eff;
    logic signed [27:0]  err_wide;
    logic signed [26:0]  err_sat;
    logic signed [26:0]  prev_eff;
    logic signed [27:0]  derr;
    logic [27:0]         derr_mag;
    logic signed [48:0]  integ_sum;
    logic signed [47:0]  integ_sat;
    logic signed [49:0]  pid_sum;
    logic signed [DB-1:0] demand_new;
    logic signed [DB:0]  drive;
    logic [DB-1:0]       mag;
    logic [7:0]          leg1, leg2;
    logic                step_up;

    assign period   = (loop_period_ms == 10'd0) ? 10'd1 : loop_period_ms;
    assign interval = now_reg - last_edge_reg;

    // divide operands: speed on A edge, derivative on tick
    always_comb
    begin
        speed_eff = ((now_us - last_edge_reg) > 32'(STALL_TIMEOUT_US)) ? 26'd0 : speed_reg;
        err_wide  = 28'(target_speed) - $signed({2'b00, speed_eff});
        if (err_wide > 28'sd67108863)
            err_sat = 27'sd67108863;
        else if (err_wide < -28'sd67108864)
            err_sat = -27'sd67108864;
        else
            err_sat = err_wide[26:0];
        prev_eff = (target_speed == 26'sd0) ? 27'sd0 : prev_err_reg;
        derr     = 28'(err_sat) - 28'(prev_eff);
        derr_mag = derr[27] ? 28'(-derr) : 28'(derr);
        div_start = 1'b0;
        div_neg   = 1'b0;
        div_a     = SPEED_NUMER;
        div_b     = now_us - last_edge_reg;
        unique case (ctl.op)
            OP_EDGE_A_START:
            begin
                div_start = 1'b1;
            end
            OP_TICK_START:
            begin
                div_start = 1'b1;
                div_neg   = derr[27];
                div_a     = {4'd0, derr_mag};
                div_b     = {22'd0, period};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    epmd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .neg      (div_neg),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // integral update, saturating to 48 bits; PID sum clamped to the demand range
    always_comb
    begin
        integ_sum = 49'(integ_reg) + 49'(err_reg * $signed({1'b0, period}));
        if (integ_sum > 49'sh0_7FFF_FFFF_FFFF)
            integ_sat = 48'sh7FFF_FFFF_FFFF;
        else if (integ_sum < -49'sh0_8000_0000_0000)
            integ_sat = 48'sh8000_0000_0000;
        else
            integ_sat = integ_sum[47:0];
        pid_sum = 50'(p_reg) + 50'(integ_reg) + 50'(div_q);
        if (pid_sum > 50'(DUTY_MAX - 48'sd1))
            demand_new = DB'(DUTY_MAX - 48'sd1);
        else if (pid_sum < -50'(DUTY_MAX - 48'sd1))
            demand_new = -DB'(DUTY_MAX - 48'sd1);
        else
            demand_new = pid_sum[DB-1:0];
    end

    assign step_up = (ctl.op == OP_EDGE_A_DONE) ? (line_a == level_b_reg)
                                                : (level_a_reg == line_b);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg   <= 1'b0;
            level_b_reg   <= 1'b0;
            last_edge_reg <= '0;
            last_loop_reg <= '0;
            speed_reg     <= '0;
            count_reg     <= '0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            demand_reg    <= '0;
            now_reg       <= '0;
            err_reg       <= '0;
            p_reg         <= '0;
            pid_go_reg    <= 1'b0;
        end
        else
        begin
            unique case (ctl.op)
                OP_EDGE_A_START:
                begin
                    now_reg <= now_us;
                end
                OP_EDGE_A_DONE:
                begin
                    speed_reg     <= (interval == 32'd0) ? SPEED_NUMER[25:0]
                                                         : div_q[25:0];
                    last_edge_reg <= now_reg;
                    level_a_reg   <= line_a;
                    count_reg     <= step_up ? count_reg + 32'd1 : count_reg - 32'd1;
                end
                OP_EDGE_B:
                begin
                    level_b_reg <= line_b;
                    count_reg   <= step_up ? count_reg + 32'd1 : count_reg - 32'd1;
                end
                OP_TICK_START:
                begin
                    speed_reg  <= speed_eff;
                    now_reg    <= now_us;
                    err_reg    <= err_sat;
                    if (target_speed == 26'sd0)
                        integ_reg <= '0;
                end
                OP_TICK_PI:
                begin
                    p_reg        <= 44'(err_reg * $signed({1'b0, prop_gain})) / 256;
                    integ_reg    <= integ_sat;
                    prev_err_reg <= err_reg;
                end
                OP_TICK_DONE:
                begin
                    demand_reg    <= demand_new;
                    last_loop_reg <= now_reg;
                end
                OP_TICK_SKIP:
                begin
                    speed_reg <= speed_eff;
                end
                default:
                begin
                    // no op: state holds
                end
            endcase
            pid_go_reg <= ({10'd0, now_us - last_loop_reg} >
                           42'(loop_period_ms) * 42'd1000);
        end
    end

    // duty mapping with minimum floor and leg swap
    always_comb
    begin
        drive = (DB+1)'(demand_reg);
        if (demand_reg > 0 && drive <= $signed({1'b0, (DB)'(min_duty)}))
            drive = $signed({1'b0, (DB)'(min_duty)});
        else if (demand_reg < 0 && drive >= -$signed({1'b0, (DB)'(min_duty)}))
            drive = -$signed({1'b0, (DB)'(min_duty)});
        mag  = drive[DB] ? DB'(-drive) : DB'(drive);
        leg1 = (drive < 0) ? mag[7:0] : 8'd0;
        leg2 = (drive > 0) ? mag[7:0] : 8'd0;
    end

    assign duty_first     = reverse_wiring ? leg2 : leg1;
    assign duty_second    = reverse_wiring ? leg1 : leg2;
    assign measured_speed = speed_reg;
    assign position       = count_reg;
    assign stat.div_done  = div_done;
    assign stat.run_pid   = pid_go_reg && (cmd == CMD_TICK);

endmodule

/* rtl/epmd_ctrl.sv */
// ----------------------------------------------------------------------------
// epmd_ctrl
// Sequencer: accepts items, steps the datapath, holds the result register.
// ----------------------------------------------------------------------------
module epmd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 loop_ran,
    output logic                 snap,
    output epmd_pkg::epmd_cmd_t  ctl,
    input  epmd_pkg::epmd_stat_t stat
);
    import epmd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_WAIT_A, S_TICK_CHK, S_WAIT_D, S_PI, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic   ran_reg;
    logic   out_valid_reg;
    logic   loop_ran_reg;

    always_comb
    begin
        ctl.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (cmd == CMD_EDGE_A)
                        ctl.op = OP_EDGE_A_START;
                    else if (cmd == CMD_EDGE_B)
                        ctl.op = OP_EDGE_B;
                end
            end
            S_WAIT_A:   ctl.op = stat.div_done ? OP_EDGE_A_DONE : OP_NONE;
            S_TICK_CHK: ctl.op = stat.run_pid ? OP_TICK_START : OP_TICK_SKIP;
            S_WAIT_D:   ctl.op = stat.div_done ? OP_TICK_PI : OP_NONE;
            S_DONE:     ctl.op = OP_TICK_DONE;
            default:    ctl.op = OP_NONE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // load the result register once it is empty or being taken
    assign snap = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // one item in flight; a finished item waits in S_OUT while the register is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ran_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            loop_ran_reg  <= 1'b0;
        end
        else
        begin
            if (snap)
            begin
                out_valid_reg <= 1'b1;
                loop_ran_reg  <= ran_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        ran_reg <= 1'b0;
                        priority if (cmd == CMD_EDGE_A)
                            state_reg <= S_WAIT_A;
                        else if (cmd == CMD_TICK)
                            state_reg <= S_TICK_CHK;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_WAIT_A:   if (stat.div_done) state_reg <= S_OUT;
                S_TICK_CHK:
                begin
                    state_reg <= stat.run_pid ? S_WAIT_D : S_OUT;
                    ran_reg   <= stat.run_pid;
                end
                S_WAIT_D:   if (stat.div_done) state_reg <= S_PI;
                S_PI:       state_reg <= S_DONE;
                S_DONE:     state_reg <= S_OUT;
                S_OUT:      if (snap) state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign loop_ran  = loop_ran_reg;

    property p_idle_accept;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall;
    endproperty
    a_idle_accept: assert property (p_idle_accept) else $error("accept while busy");

    property p_pid_flag;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> ran_reg;
    endproperty
    a_pid_flag: assert property (p_pid_flag) else $error("PID ran without flag");

    property p_out_after;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid_reg;
    endproperty
    a_out_after: assert property (p_out_after) else $error("result lost");

endmodule

/* rtl/encoder_pid_motor_drive_unit.sv */
// ----------------------------------------------------------------------------
// encoder_pid_motor_drive_unit
// Quadrature encoder tracker with fixed-point PID H-bridge drive.
// ----------------------------------------------------------------------------
// One item is worked at a time. A B edge, an unused code and a tick with no
// PID update need no divide; an A edge and a tick that runs the PID law each
// wait on the shared divider (speed and derivative term respectively). Results
// sit in an output register so the next item can be accepted while a finished
// result waits; a finished item holds in its last step until that register is
// free. Configuration is to be written through the cfg port only while idle;
// the block itself does not enforce this.
module encoder_pid_motor_drive_unit #(
    parameter int DUTY_BITS        = 8,
    parameter int STALL_TIMEOUT_US = 500000
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic               line_a,
    input  logic               line_b,
    input  logic [31:0]        now_us,
    input  logic signed [25:0] target_speed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         duty_first,
    output logic [7:0]         duty_second,
    output logic [25:0]        measured_speed,
    output logic signed [31:0] position,
    output logic               loop_ran,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import epmd_pkg::*;

    logic [15:0] prop_gain_reg;
    logic [9:0]  period_reg;
    logic [7:0]  min_duty_reg;
    logic        reverse_reg;
    epmd_cmd_t   ctl;
    epmd_stat_t  stat;
    logic        snap;
    logic [7:0]  d1, d2;
    logic [25:0] spd;
    logic signed [31:0] pos;
    logic [1:0]  cmd_reg;
    logic        la_reg, lb_reg;
    logic [31:0] now_reg;
    logic signed [25:0] tgt_reg;
    logic [7:0]  d1_reg, d2_reg;
    logic [25:0] spd_reg;
    logic signed [31:0] pos_reg;
    logic        in_take;
    logic        dp_la, dp_lb;
    logic [31:0] dp_now;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg <= 16'd256;
            period_reg    <= 10'd10;
            min_duty_reg  <= 8'd0;
            reverse_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN: prop_gain_reg <= cfg_data;
                REG_PERIOD:    period_reg    <= cfg_data[9:0];
                REG_MIN_DUTY:  min_duty_reg  <= cfg_data[7:0];
                REG_REVERSE:   reverse_reg   <= cfg_data[0];
                default:       reverse_reg   <= reverse_reg;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    assign in_take = in_valid && !in_stall;

    // hold the accepted item's fields and load the result register on snap
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= cmd;
            la_reg  <= line_a;
            lb_reg  <= line_b;
            now_reg <= now_us;
            tgt_reg <= target_speed;
        end
        if (snap)
        begin
            d1_reg  <= d1;
            d2_reg  <= d2;
            spd_reg <= spd;
            pos_reg <= pos;
        end
    end

    // the accept cycle already steps the datapath, so it sees the live fields
    assign dp_la  = in_take ? line_a : la_reg;
    assign dp_lb  = in_take ? line_b : lb_reg;
    assign dp_now = in_take ? now_us : now_reg;

    epmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .loop_ran  (loop_ran),
        .snap      (snap),
        .ctl       (ctl),
        .stat      (stat)
    );

    epmd_datapath #(
        .DUTY_BITS        (DUTY_BITS),
        .STALL_TIMEOUT_US (STALL_TIMEOUT_US)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd_reg),
        .line_a         (dp_la),
        .line_b         (dp_lb),
        .now_us         (dp_now),
        .target_speed   (tgt_reg),
        .prop_gain      (prop_gain_reg),
        .loop_period_ms (period_reg),
        .min_duty       (min_duty_reg),
        .reverse_wiring (reverse_reg),
        .duty_first     (d1),
        .duty_second    (d2),
        .measured_speed (spd),
        .position       (pos)
    );

    assign duty_first     = d1_reg;
    assign duty_second    = d2_reg;
    assign measured_speed = spd_reg;
    assign position       = pos_reg;

endmodule
